/* src/assert_macros.svh */
// Assertion macros for the lag split block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TRL_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define TRL_ASSERT(lbl, prop, msg)
`define TRL_ASSERT_IMPLY(lbl, pre, post, msg)
`endif

`endif

/* src/trl_pkg.sv */
`default_nettype none

package trl_pkg;

  localparam int MAX_LAG_DEF_C = 16;
  localparam int LAG_CNT_W_C   = 5;
  localparam int QW_C          = 24;
  localparam int NUM_W_C       = 56;
  localparam int DEN_W_C       = 32;

  localparam logic [QW_C:0] SHARE_ONE_C = 25'h100_0000;

  typedef struct packed {
    logic [15:0] peak_lag;
    logic [16:0] area_share;
    logic [31:0] runoff_flow;
  } trl_in_t;

  typedef struct packed {
    logic [3:0]  lag_index;
    logic [31:0] lag_contribution;
    logic        last_lag;
  } trl_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } trl_div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_PSQ,
    ST_LAG,
    ST_SQ,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_INC,
    ST_MUL_H,
    ST_MUL_L,
    ST_EMIT
  } trl_state_t;

endpackage

`default_nettype wire

/* src/trl_div.sv */
`default_nettype none

module trl_div import trl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NUM_W_C-1:0]   num,
  input  wire logic [DEN_W_C-1:0]   den,
  output trl_div_stat_t             stat,
  output logic [QW_C-1:0]           quo
);

  localparam int CNT_W = $clog2(QW_C + 1);

  logic [DEN_W_C-1:0] rem_r, rem_nxt;
  logic [QW_C-1:0]    low_r, low_nxt;
  logic [QW_C-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  logic [DEN_W_C:0]   trial;
  logic [DEN_W_C:0]   diff;
  logic               ge;

  // restoring step: one quotient bit per cycle
  assign trial = {rem_r, low_r[QW_C-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num[NUM_W_C-1:QW_C];
      low_nxt  = num[QW_C-1:0];
      cnt_nxt  = CNT_W'(QW_C);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W_C-1:0] : trial[DEN_W_C-1:0];
      low_nxt = {low_r[QW_C-2:0], 1'b0};
      q_nxt   = {q_r[QW_C-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;

endmodule

`default_nettype wire

/* src/triangular_runoff_lag_split.sv */
// Triangular lag split of one grid cell's runoff.
// Input channel (in_valid/in_ready/in_data): one request per cell carrying the
// peak lag (Q8.8), area share (Q1.16) and runoff flow (Q16.16).
// Result channel (out_valid/out_ready/out_data): one result per lag slot,
// lag_index 0..n-1, the flow for that slot and last_lag on the final one,
// where n is lag_count limited to 1..MAX_LAG.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes lag_count, always ready;
// write only while the block is idle.
// Sequence: a request first forms the share product and the peak square; each
// lag slot then squares its base and divides in the bit-serial divider (both
// skipped once its share is already one), scales its increment and emits.
// One 32x25 multiplier is shared by the share product, the squares and the
// scaling of each increment; the divider sets most of the per-slot time.
// in_ready is high only while no cell is in progress. A finished result waits
// in the output register; a stalled receiver holds the sequencer at the next
// result, and the final result may wait while the next request is taken.
// Reset (synchronous, rst_n low) empties the output register, returns the
// sequencer to idle and sets lag_count to 1.
`default_nettype none

`include "assert_macros.svh"

module triangular_runoff_lag_split import trl_pkg::*; #(
  parameter int MAX_LAG = MAX_LAG_DEF_C
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire trl_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output trl_out_t                    out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [LAG_CNT_W_C-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_LAG + 1);

  trl_state_t state_r, state_nxt;

  logic [LAG_CNT_W_C-1:0] lag_count_r;
  logic                   out_valid_r, out_valid_nxt;
  trl_out_t               out_r, out_nxt;

  trl_in_t                in_r, in_nxt;
  logic [LW-1:0]          lag_r, lag_nxt;
  logic [LW-1:0]          n_r, n_nxt;
  logic [48:0]            prod_r, prod_nxt;
  logic [31:0]            psq_r, psq_nxt;
  logic [15:0]            base_r, base_nxt;
  logic                   rise_r, rise_nxt;
  logic [31:0]            sq_r, sq_nxt;
  logic [QW_C:0]          cur_r, cur_nxt;
  logic [QW_C:0]          prev_r, prev_nxt;
  logic [QW_C:0]          inc_r, inc_nxt;
  logic [49:0]            hi_r, hi_nxt;
  logic [QW_C:0]          lo_r, lo_nxt;

  logic [31:0]            mul_a;
  logic [24:0]            mul_b;
  logic [56:0]            mul_p;

  logic                   div_start;
  logic [NUM_W_C-1:0]     div_num;
  trl_div_stat_t          div_stat;
  logic [QW_C-1:0]        div_quo;

  logic [31:0]            lc32;
  logic [31:0]            n32;
  logic [31:0]            lag32;
  logic [31:0]            twice32;
  logic [50:0]            sum;
  logic [34:0]            val;
  logic [LW+3:0]          idx_ext;

  assign mul_p = mul_a * mul_b;

  assign div_num = rise_r ? ({24'b0, sq_r} << 39) : ({24'b0, sq_r} << 23);

  trl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (psq_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  assign lc32    = 32'(lag_count_r);
  assign n32     = (lc32 == 32'd0) ? 32'd1 :
                   (lc32 > 32'(MAX_LAG)) ? 32'(MAX_LAG) : lc32;
  assign lag32   = 32'(lag_r);
  assign twice32 = {15'b0, in_r.peak_lag, 1'b0};
  assign sum     = {1'b0, hi_r} + {26'b0, lo_r};
  assign val     = sum[50:16];
  assign idx_ext = {4'b0, lag_r - LW'(1)};

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    in_nxt        = in_r;
    lag_nxt       = lag_r;
    n_nxt         = n_r;
    prod_nxt      = prod_r;
    psq_nxt       = psq_r;
    base_nxt      = base_r;
    rise_nxt      = rise_r;
    sq_nxt        = sq_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    inc_nxt       = inc_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt    = in_data;
          n_nxt     = LW'(n32);
          lag_nxt   = LW'(1);
          prev_nxt  = '0;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        mul_a     = in_r.runoff_flow;
        mul_b     = {8'b0, in_r.area_share};
        prod_nxt  = mul_p[48:0];
        state_nxt = ST_PSQ;
      end
      ST_PSQ: begin
        mul_a     = {16'b0, in_r.peak_lag};
        mul_b     = {9'b0, in_r.peak_lag};
        psq_nxt   = mul_p[31:0];
        state_nxt = ST_LAG;
      end
      ST_LAG: begin
        if (twice32 < ((lag32 + 32'd1) << 8)) begin
          cur_nxt   = SHARE_ONE_C;
          state_nxt = ST_INC;
        end else if ((lag32 << 8) <= {16'b0, in_r.peak_lag}) begin
          base_nxt  = 16'(lag_r);
          rise_nxt  = 1'b1;
          state_nxt = ST_SQ;
        end else begin
          base_nxt  = 16'(twice32 - (lag32 << 8));
          rise_nxt  = 1'b0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_a     = {16'b0, base_r};
        mul_b     = {9'b0, base_r};
        sq_nxt    = mul_p[31:0];
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          cur_nxt   = rise_r ? {1'b0, div_quo} : (SHARE_ONE_C - {1'b0, div_quo});
          state_nxt = ST_INC;
        end
      end
      ST_INC: begin
        inc_nxt   = (cur_r > prev_r) ? (cur_r - prev_r) : '0;
        prev_nxt  = cur_r;
        state_nxt = ST_MUL_H;
      end
      ST_MUL_H: begin
        mul_a     = {7'b0, prod_r[48:24]};
        mul_b     = inc_r;
        hi_nxt    = mul_p[49:0];
        state_nxt = ST_MUL_L;
      end
      ST_MUL_L: begin
        mul_a     = {8'b0, prod_r[23:0]};
        mul_b     = inc_r;
        lo_nxt    = mul_p[48:24];
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_nxt.lag_index        = idx_ext[3:0];
          out_nxt.lag_contribution = (|val[34:32]) ? 32'hFFFF_FFFF : val[31:0];
          out_nxt.last_lag         = (lag_r == n_r);
          if (lag_r == n_r) begin
            state_nxt = ST_IDLE;
          end else begin
            lag_nxt   = lag_r + LW'(1);
            state_nxt = ST_LAG;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lag_count_r <= LAG_CNT_W_C'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        lag_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    in_r   <= in_nxt;
    lag_r  <= lag_nxt;
    n_r    <= n_nxt;
    prod_r <= prod_nxt;
    psq_r  <= psq_nxt;
    base_r <= base_nxt;
    rise_r <= rise_nxt;
    sq_r   <= sq_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    inc_r  <= inc_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TRL_ASSERT_IMPLY(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `TRL_ASSERT_IMPLY(a_quo_range, div_stat.done, div_quo <= 24'h80_0000, "share quotient out of range")
  `TRL_ASSERT_IMPLY(a_inc_range, state_r == ST_MUL_H, inc_r <= SHARE_ONE_C, "increment above one")
  `TRL_ASSERT_IMPLY(a_prev_range, state_r != ST_IDLE && state_r != ST_PROD, prev_r <= SHARE_ONE_C, "cumulative share above one")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import trl_pkg::*;

  localparam int          QUIET_LIMIT = 4000;
  localparam int          SQUEEZE_CYCLES = 400;
  localparam int          TAIL_CYCLES = 600;
  localparam bit [63:0]   Q24_ONE = 64'd1 << 24;
  localparam int          N_ROWS = 21;
  localparam int          N_PHASES = 6;

  // lags, peak_lag, area_share, runoff_flow, typed, typed_flow
  typedef struct packed {
    logic [4:0]  lags;
    trl_in_t     req;
    logic        typed;
    logic [31:0] typed_flow;
  } cell_row_t;

  localparam cell_row_t DIR_ROWS [N_ROWS] = '{
    {5'd1,  16'h0000, 17'h10000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    {5'd1,  16'h0000, 17'h00000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    {5'd1,  16'h0000, 17'h10000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    {5'd1,  16'h0000, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    {5'd1,  16'h00FF, 17'h10000, 32'h1234_5678, 1'b1, 32'h1234_5678},
    {5'd1,  16'h0100, 17'h10000, 32'h0001_0000, 1'b0, 32'h0},
    {5'd1,  16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    {5'd16, 16'h0100, 17'h10000, 32'h0001_0000, 1'b0, 32'h0},
    {5'd16, 16'h0800, 17'h10000, 32'h8000_0000, 1'b0, 32'h0},
    {5'd16, 16'hFFFF, 17'h10000, 32'hFFFF_FFFF, 1'b0, 32'h0},
    {5'd16, 16'h0000, 17'h10000, 32'h0003_0000, 1'b0, 32'h0},
    {5'd16, 16'h0180, 17'h1FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    {5'd16, 16'h0A5A, 17'h0AAAA, 32'h5A5A_5A5A, 1'b0, 32'h0},
    {5'd0,  16'h0000, 17'h10000, 32'h0000_ABCD, 1'b1, 32'h0000_ABCD},
    {5'd0,  16'h0300, 17'h08000, 32'h7FFF_FFFF, 1'b0, 32'h0},
    {5'd31, 16'h07FF, 17'h10000, 32'h0001_0000, 1'b0, 32'h0},
    {5'd31, 16'h8000, 17'h10000, 32'h4000_0000, 1'b0, 32'h0},
    {5'd17, 16'h00FF, 17'h10000, 32'h0000_0001, 1'b0, 32'h0},
    {5'd17, 16'h1000, 17'h10000, 32'hFFFF_FFFF, 1'b0, 32'h0},
    {5'd2,  16'h0180, 17'h10000, 32'h0001_0000, 1'b0, 32'h0},
    {5'd2,  16'h0100, 17'h10000, 32'h0001_0000, 1'b0, 32'h0}
  };

  localparam logic [4:0] PHASE_LAGS [N_PHASES] = '{5'd3, 5'd16, 5'd31, 5'd0, 5'd1, 5'd9};
  localparam int         PHASE_LEN  [N_PHASES] = '{25, 20, 20, 15, 20, 30};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  trl_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  trl_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_data;

  trl_out_t   lag_flows_due [$];
  logic [4:0] lag_setting;
  int         fail_count = 0;
  int         quiet_cycles = 0;
  int         in_calm = 0;
  bit         squeeze_armed = 1'b0;

  triangular_runoff_lag_split DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cumulative triangular share at lag l, Q1.24
  function automatic bit [63:0] cum_weight(input bit [63:0] pk, input bit [63:0] l);
    bit [63:0] twice;
    bit [63:0] d;
    bit [63:0] q;
    twice = pk * 2;
    if (twice < 256 * (l + 1))
      return Q24_ONE;
    if (256 * l <= pk) begin
      q = ((l * l) << 39) / (pk * pk);
      return (q > Q24_ONE) ? Q24_ONE : q;
    end
    d = twice - 256 * l;
    q = ((d * d) << 23) / (pk * pk);
    return (q >= Q24_ONE) ? 64'd0 : Q24_ONE - q;
  endfunction

  task automatic predict_cell(input trl_in_t c);
    bit [63:0] prod;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] prev;
    bit [63:0] cur;
    bit [63:0] rise;
    bit [63:0] flow;
    int        n;
    trl_out_t  r;
    prod = 64'(c.area_share) * 64'(c.runoff_flow);
    hi = prod >> 24;
    lo = prod & (Q24_ONE - 1);
    n = int'(lag_setting);
    if (n == 0)
      n = 1;
    if (n > MAX_LAG_DEF_C)
      n = MAX_LAG_DEF_C;
    prev = 0;
    for (int l = 1; l <= n; l++) begin
      cur = cum_weight(64'(c.peak_lag), 64'(l));
      rise = (cur > prev) ? cur - prev : 64'd0;
      flow = (hi * rise + ((lo * rise) >> 24)) >> 16;
      prev = cur;
      r.lag_index = 4'(l - 1);
      r.lag_contribution = (flow > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : flow[31:0];
      r.last_lag = (l == n);
      lag_flows_due = {lag_flows_due, r};
    end
  endtask

  task automatic send_cell(input trl_in_t c, input bit typed, input logic [31:0] typed_flow);
    int gap;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0)
        in_calm = $urandom_range(5, 20);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (typed)
      lag_flows_due = {lag_flows_due, trl_out_t'({4'd0, typed_flow, 1'b1})};
    else
      predict_cell(c);
    @(negedge clk);
  endtask

  task automatic wait_all_flows;
    in_valid <= 1'b0;
    @(negedge clk);
    while (lag_flows_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_lag_count(input logic [4:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    lag_setting = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int       gap;
    int       calm;
    trl_out_t want;
    calm = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (squeeze_armed) begin
        squeeze_armed = 1'b0;
        gap = SQUEEZE_CYCLES;
      end else if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0)
          calm = $urandom_range(5, 30);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (lag_flows_due.size() == 0) begin
        $error("unexpected lag result: lag_index %0d lag_contribution %h last_lag %b",
               out_data.lag_index, out_data.lag_contribution, out_data.last_lag);
        fail_count++;
      end else begin
        want = lag_flows_due.pop_front();
        if (out_data.lag_index !== want.lag_index) begin
          $error("lag_index: expected %0d, got %0d", want.lag_index, out_data.lag_index);
          fail_count++;
        end
        if (out_data.lag_contribution !== want.lag_contribution) begin
          $error("lag_contribution: expected %h, got %h",
                 want.lag_contribution, out_data.lag_contribution);
          fail_count++;
        end
        if (out_data.last_lag !== want.last_lag) begin
          $error("last_lag: expected %b, got %b", want.last_lag, out_data.last_lag);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    trl_in_t    c;
    logic [4:0] lags;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    lag_setting = 5'd1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].lags != lag_setting) begin
        wait_all_flows();
        write_lag_count(DIR_ROWS[i].lags);
      end
      send_cell(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].typed_flow);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      lags = (p == N_PHASES - 1) ? 5'($urandom_range(2, 15)) : PHASE_LAGS[p];
      wait_all_flows();
      write_lag_count(lags);
      // long receiver hold-off while requests keep coming
      if (p == 0)
        squeeze_armed = 1'b1;
      for (int k = 0; k < PHASE_LEN[p]; k++) begin
        case ($urandom_range(0, 5))
          0:       c.peak_lag = 16'h0000;
          1:       c.peak_lag = 16'($urandom_range(0, 16'h03FF));
          2, 3:    c.peak_lag = 16'($urandom_range(16'h0100, 16'h1200));
          default: c.peak_lag = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0:       c.area_share = 17'h10000;
          1:       c.area_share = 17'($urandom);
          default: c.area_share = 17'($urandom_range(0, 17'h10000));
        endcase
        case ($urandom_range(0, 9))
          0:       c.runoff_flow = 32'h0000_0000;
          1:       c.runoff_flow = 32'hFFFF_FFFF;
          default: c.runoff_flow = $urandom;
        endcase
        send_cell(c, 1'b0, 32'h0);
      end
    end

    wait_all_flows();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
